[rtl/core/isa_pkg.sv]
// isa_pkg: shared widths, register codes, reset values and the
// controller/datapath command and status types for the inverter sense block.
// no dependencies.
package isa_pkg;

  // ring of stored results and raw sample width
  localparam int RING_DEPTH  = 50;
  localparam int SAMPLE_BITS = 12;

  // configuration register geometry
  localparam int GAIN_BITS      = 24;
  localparam int OFFSET_BITS    = 18;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int FRAC_BITS      = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BUS_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BUS_OFFSET     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_A_GAIN   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_A_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_B_GAIN   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_B_OFFSET = 3'd5;

  localparam logic [GAIN_BITS-1:0]   BUS_GAIN_RST       = 24'd1671168;
  localparam logic [OFFSET_BITS-1:0] BUS_OFFSET_RST     = -18'sd40800;
  localparam logic [GAIN_BITS-1:0]   PHASE_A_GAIN_RST   = 24'd58196;
  localparam logic [OFFSET_BITS-1:0] PHASE_A_OFFSET_RST = -18'sd1680;
  localparam logic [GAIN_BITS-1:0]   PHASE_B_GAIN_RST   = 24'd33948;
  localparam logic [OFFSET_BITS-1:0] PHASE_B_OFFSET_RST = -18'sd830;

  // scaling: floor(gain * sample / 2^16) + offset
  localparam int RAW_PROD_BITS = GAIN_BITS + SAMPLE_BITS;
  localparam int PROD_BITS     = RAW_PROD_BITS - FRAC_BITS;
  localparam int SCALED_BITS   =
    ((PROD_BITS > OFFSET_BITS - 1) ? PROD_BITS : OFFSET_BITS - 1) + 2;

  // beta = floor((alpha + 2*b) * 1/sqrt3)
  localparam int SUM_BITS   = SCALED_BITS + 2;
  localparam int COEF_BITS  = 16;
  localparam logic [COEF_BITS-1:0] INV_SQRT3_Q16 = 16'd37837;
  localparam int BPROD_BITS = SUM_BITS + COEF_BITS + 1;

  // magnitude: isqrt(alpha^2 + beta^2)
  localparam int ABS_BITS  = SUM_BITS;
  localparam int SQ_BITS   = 2 * ABS_BITS;
  localparam int RAD_BITS  = SQ_BITS + 1;
  localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
  localparam int RAD_PAD   = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 1;
  localparam int ITER_BITS = $clog2(ROOT_BITS + 1);

  // stored results and their running totals
  localparam int OUT_BITS   = 16;
  localparam int SLOT_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TOTAL_BITS = $clog2(RING_DEPTH * 65535 + 1);

  // mean by reciprocal multiply, exact for every total below 2^TOTAL_BITS
  localparam int DIV_SHIFT = TOTAL_BITS + $clog2(RING_DEPTH);
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
  localparam int MULT_BITS = $clog2(DIV_MULT + 1);
  localparam int QPROD_BITS = TOTAL_BITS + MULT_BITS;

  typedef struct packed {
    logic load;
    logic scale;
    logic offs;
    logic beta;
    logic square;
    logic rad;
    logic root;
    logic update;
    logic divide;
    logic out_load;
  } isa_cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } isa_sts_t;

endpackage

[rtl/core/isa_in_if.sv]
// isa_in_if: input channel carrying one conversion frame of three samples.
// depends on isa_pkg for the sample width.
interface isa_in_if import isa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] bus_sample;
  logic [SAMPLE_BITS-1:0] phase_a_sample;
  logic [SAMPLE_BITS-1:0] phase_b_sample;

  modport source (output valid, output bus_sample, output phase_a_sample,
                  output phase_b_sample, input ready);
  modport sink (input valid, input bus_sample, input phase_a_sample,
                input phase_b_sample, output ready);
endinterface

[rtl/core/isa_out_if.sv]
// isa_out_if: result channel carrying the two moving averages.
// depends on isa_pkg for the result width.
interface isa_out_if import isa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] avg_bus_voltage;
  logic [OUT_BITS-1:0] avg_current_peak;

  modport source (output valid, output avg_bus_voltage, output avg_current_peak,
                  input ready);
  modport sink (input valid, input avg_bus_voltage, input avg_current_peak,
                output ready);
endinterface

[rtl/core/inverter_sense_scale_and_average_top.sv]
// Inverter sense scaling and moving average. Each accepted frame (bus voltage,
// phase A and phase B samples) is scaled by its gain and offset, the current
// magnitude is formed as the truncated square root of alpha^2 + beta^2, and
// both values, clamped to 0..65535, enter a ring of RING_DEPTH entries. One
// transaction comes back per frame with the truncated means over the whole
// ring; empty entries count as zero after reset, and the first frame lands in
// slot 1. Frames are handled one at a time, and the bit-serial square root
// retires one root bit per cycle. A waiting result does not stop the next
// frame from being accepted, but that frame waits in ST_HOLD until the result
// is taken. No clearing pass follows reset. The user must write the registers
// only while idle; the block itself does not enforce this.
// depends on isa_pkg, isa_in_if, isa_out_if, isa_ctrl and isa_dpath.
module inverter_sense_scale_and_average_top import isa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  isa_in_if.sink                    in_if,
  isa_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  isa_cmd_t cmd;
  isa_sts_t sts;

  isa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  isa_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .bus_sample       (in_if.bus_sample),
    .phase_a_sample   (in_if.phase_a_sample),
    .phase_b_sample   (in_if.phase_b_sample),
    .cmd              (cmd),
    .sts              (sts),
    .avg_bus_voltage  (out_if.avg_bus_voltage),
    .avg_current_peak (out_if.avg_current_peak)
  );

endmodule

[rtl/core/isa_ctrl.sv]
// isa_ctrl: sequencer for one frame at a time and the result valid flag.
// depends on isa_pkg for the command and status structs.
module isa_ctrl import isa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  isa_sts_t sts,
  output isa_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_OFFS,
    ST_BETA,
    ST_SQUARE,
    ST_RAD,
    ST_ROOT,
    ST_UPDATE,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.offs  = 1'b1;
        state_nxt = ST_BETA;
      end
      ST_BETA: begin
        cmd.beta  = 1'b1;
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_RAD;
      end
      ST_RAD: begin
        cmd.rad   = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root = 1'b1;
        if (sts.sqrt_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_nxt  = ST_HOLD;
      end
      ST_HOLD: begin
        // output register free or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/isa_dpath.sv]
// isa_dpath: configuration registers, scaling multipliers, beta and squares,
// bit-serial square root, result ring with totals, and mean by reciprocal.
// depends on isa_pkg.
module isa_dpath import isa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]    bus_sample,
  input  logic [SAMPLE_BITS-1:0]    phase_a_sample,
  input  logic [SAMPLE_BITS-1:0]    phase_b_sample,
  input  isa_cmd_t                  cmd,
  output isa_sts_t                  sts,
  output logic [OUT_BITS-1:0]       avg_bus_voltage,
  output logic [OUT_BITS-1:0]       avg_current_peak
);

  // configuration
  logic [GAIN_BITS-1:0]   bus_gain_r, pa_gain_r, pb_gain_r;
  logic [OFFSET_BITS-1:0] bus_off_r, pa_off_r, pb_off_r;

  // frame pipeline
  logic [SAMPLE_BITS-1:0]   samp_bus_r, samp_pa_r, samp_pb_r;
  logic [RAW_PROD_BITS-1:0] prod_bus_r, prod_pa_r, prod_pb_r;
  logic [SCALED_BITS-1:0]   vbus_r, alpha_r, ib_r;
  logic [BPROD_BITS-1:0]    bprod_r;
  logic [SQ_BITS-1:0]       sq_a_r, sq_b_r;

  // square root
  logic [RAD_PAD-1:0]   rad_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [ROOT_BITS-1:0] root_r;
  logic [ITER_BITS-1:0] iter_r;

  // ring and totals
  logic [2*OUT_BITS-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_r;
  logic [2*OUT_BITS-1:0] rd_r;
  logic                  rd_vld_r;
  logic [SLOT_BITS-1:0]  slot_r, slot_nxt;
  logic [TOTAL_BITS-1:0] vtot_r, ctot_r, vtot_nxt, ctot_nxt;
  logic [QPROD_BITS-1:0] vq_r, cq_r;
  logic [OUT_BITS-1:0]   out_v_r, out_c_r;

  // combinational helpers
  logic signed [SUM_BITS-1:0] alpha_ext, ib_x2, beta_sum, beta_val;
  logic [ABS_BITS-1:0]        a_abs, b_abs;
  logic [REM_BITS+2:0]        trial;
  logic [REM_BITS+1:0]        rem_shift;
  logic [OUT_BITS-1:0]        v16, c16, old_v, old_c;

  function automatic logic [SCALED_BITS-1:0] add_offset(
    input logic [RAW_PROD_BITS-1:0] prod,
    input logic [OFFSET_BITS-1:0]   off
  );
    logic [SCALED_BITS-1:0] p_ext, o_ext;
    p_ext = {{(SCALED_BITS-PROD_BITS){1'b0}}, prod[RAW_PROD_BITS-1:FRAC_BITS]};
    o_ext = {{(SCALED_BITS-OFFSET_BITS){off[OFFSET_BITS-1]}}, off};
    return p_ext + o_ext;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_gain_r <= BUS_GAIN_RST;
      bus_off_r  <= BUS_OFFSET_RST;
      pa_gain_r  <= PHASE_A_GAIN_RST;
      pa_off_r   <= PHASE_A_OFFSET_RST;
      pb_gain_r  <= PHASE_B_GAIN_RST;
      pb_off_r   <= PHASE_B_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUS_GAIN:       bus_gain_r <= cfg_data[GAIN_BITS-1:0];
        REG_BUS_OFFSET:     bus_off_r  <= cfg_data[OFFSET_BITS-1:0];
        REG_PHASE_A_GAIN:   pa_gain_r  <= cfg_data[GAIN_BITS-1:0];
        REG_PHASE_A_OFFSET: pa_off_r   <= cfg_data[OFFSET_BITS-1:0];
        REG_PHASE_B_GAIN:   pb_gain_r  <= cfg_data[GAIN_BITS-1:0];
        REG_PHASE_B_OFFSET: pb_off_r   <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign slot_nxt = (slot_r == SLOT_BITS'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // beta and magnitudes
  assign alpha_ext = {{2{alpha_r[SCALED_BITS-1]}}, alpha_r};
  assign ib_x2     = {ib_r[SCALED_BITS-1], ib_r, 1'b0};
  assign beta_sum  = alpha_ext + ib_x2;
  assign beta_val  = bprod_r[FRAC_BITS +: SUM_BITS];
  assign a_abs     = alpha_ext[SUM_BITS-1] ? (~alpha_ext + 1'b1) : alpha_ext;
  assign b_abs     = beta_val[SUM_BITS-1] ? (~beta_val + 1'b1) : beta_val;

  // one root bit per step
  assign rem_shift = {rem_r, rad_r[RAD_PAD-1 -: 2]};
  assign trial     = {1'b0, rem_shift} - {2'b00, root_r, 2'b01};
  assign sts.sqrt_done = (iter_r == ITER_BITS'(1));

  // saturation and ring update
  always_comb begin
    if (vbus_r[SCALED_BITS-1]) begin
      v16 = '0;
    end else if (|vbus_r[SCALED_BITS-2:OUT_BITS]) begin
      v16 = '1;
    end else begin
      v16 = vbus_r[OUT_BITS-1:0];
    end
    c16   = (|root_r[ROOT_BITS-1:OUT_BITS]) ? '1 : root_r[OUT_BITS-1:0];
    old_v = rd_vld_r ? rd_r[2*OUT_BITS-1:OUT_BITS] : '0;
    old_c = rd_vld_r ? rd_r[OUT_BITS-1:0] : '0;
    vtot_nxt = vtot_r - TOTAL_BITS'(old_v) + TOTAL_BITS'(v16);
    ctot_nxt = ctot_r - TOTAL_BITS'(old_c) + TOTAL_BITS'(c16);
  end

  // frame arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_bus_r <= bus_sample;
      samp_pa_r  <= phase_a_sample;
      samp_pb_r  <= phase_b_sample;
    end
    if (cmd.scale) begin
      prod_bus_r <= bus_gain_r * samp_bus_r;
      prod_pa_r  <= pa_gain_r * samp_pa_r;
      prod_pb_r  <= pb_gain_r * samp_pb_r;
    end
    if (cmd.offs) begin
      vbus_r  <= add_offset(prod_bus_r, bus_off_r);
      alpha_r <= add_offset(prod_pa_r, pa_off_r);
      ib_r    <= add_offset(prod_pb_r, pb_off_r);
    end
    if (cmd.beta) begin
      bprod_r <= beta_sum * $signed({1'b0, INV_SQRT3_Q16});
    end
    if (cmd.square) begin
      sq_a_r <= a_abs * a_abs;
      sq_b_r <= b_abs * b_abs;
    end
    if (cmd.rad) begin
      rad_r  <= RAD_PAD'(sq_a_r) + RAD_PAD'(sq_b_r);
      rem_r  <= '0;
      root_r <= '0;
      iter_r <= ITER_BITS'(ROOT_BITS);
    end else if (cmd.root) begin
      rad_r  <= {rad_r[RAD_PAD-3:0], 2'b00};
      iter_r <= iter_r - 1'b1;
      if (!trial[REM_BITS+2]) begin
        rem_r  <= trial[REM_BITS-1:0];
        root_r <= {root_r[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_shift[REM_BITS-1:0];
        root_r <= {root_r[ROOT_BITS-2:0], 1'b0};
      end
    end
    if (cmd.divide) begin
      vq_r <= vtot_r * MULT_BITS'(DIV_MULT);
      cq_r <= ctot_r * MULT_BITS'(DIV_MULT);
    end
    if (cmd.out_load) begin
      out_v_r <= vq_r[DIV_SHIFT +: OUT_BITS];
      out_c_r <= cq_r[DIV_SHIFT +: OUT_BITS];
    end
  end

  // ring storage, read early in the frame and written at update
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      rd_r <= ring_mem[slot_r];
    end
    if (cmd.update) begin
      ring_mem[slot_r] <= {v16, c16};
    end
  end

  // slot pointer, entry valid bits and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      vtot_r   <= '0;
      ctot_r   <= '0;
    end else begin
      if (cmd.load) begin
        slot_r <= slot_nxt;
      end
      if (cmd.scale) begin
        rd_vld_r <= valid_r[slot_r];
      end
      if (cmd.update) begin
        valid_r[slot_r] <= 1'b1;
        vtot_r          <= vtot_nxt;
        ctot_r          <= ctot_nxt;
      end
    end
  end

  assign avg_bus_voltage  = out_v_r;
  assign avg_current_peak = out_c_r;

endmodule
